// ----- rtl/unsh_pkg.sv -----
package unsh_pkg;

   localparam int CH_N   = 3;   // red, green, blue
   localparam int PIX_W  = 8;
   localparam int CSUM_W = 11;  // sum of five 8-bit samples

   typedef logic [CH_N-1:0][PIX_W-1:0]  px_type;     // [0] red, [1] green, [2] blue
   typedef logic [4:0][CH_N-1:0][PIX_W-1:0] col_type; // one window column, [0] oldest row
   typedef logic [3:0][CH_N-1:0][PIX_W-1:0] lines_type;
   typedef logic [CH_N-1:0][CSUM_W-1:0] csum_type;
   typedef logic [4:0][CSUM_W-1:0]      sums5_type;

   typedef enum logic [1:0] {
      REG_LAMBDA = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_idx_type;

   localparam logic [11:0] LAMBDA_RESET = 12'd384;
   localparam logic [10:0] WIDTH_RESET  = 11'd1024;
   localparam logic [10:0] HEIGHT_RESET = 11'd1024;

   typedef struct packed {
      logic       border;
      logic       last;
      logic [9:0] row;
      logic [9:0] col;
   } meta_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/unsh_lbuf.sv -----
module unsh_lbuf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [1:0]                   slot,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  unsh_pkg::px_type             pix,
   output unsh_pkg::lines_type          lines
);
   import unsh_pkg::*;

   px_type     bank_rd [4];
   logic [1:0] slot_ff;

   // four row banks; the bank written this cycle returns the row four lines up
   for (genvar b = 0; b < 4; b++) begin : g_bank
      px_type mem [MAX_WIDTH];
      px_type rd_ff;

      always_ff @(posedge clock) begin
         if (rd_en) begin
            if (slot == 2'(b)) begin
               mem[addr] <= pix;
            end
            rd_ff <= mem[addr];
         end
      end

      assign bank_rd[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         slot_ff <= slot;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lines[i] = bank_rd[2'(slot_ff + 2'(i))];
      end
   end

endmodule

// ----- rtl/unsh_cell.sv -----
module unsh_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  unsh_pkg::col_type  col_in,
   input  unsh_pkg::csum_type sum_in,
   output unsh_pkg::col_type  col_out,
   output unsh_pkg::csum_type sum_out
);
   import unsh_pkg::*;

   col_type  col_ff;
   csum_type sum_ff;

   // one window column plus its per-channel column sum
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
         sum_ff <= sum_in;
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_ff;

endmodule

// ----- rtl/unsh_calc.sv -----
module unsh_calc (
   input  logic                clock,
   input  logic signed [11:0]  lambda,
   input  unsh_pkg::sums5_type col_sums,
   input  logic [7:0]          center,
   output logic [7:0]          result
);
   import unsh_pkg::*;

   localparam int          DIV_SHIFT = 17;
   localparam logic [25:0] DIV_MULT  = 26'd5243;     // ceil(2^17 / 25)
   localparam logic [20:0] SCALE     = 21'd6400;
   localparam logic signed [26:0] SAT_LIMIT = 27'sd1638400;  // 256 * 6400

   logic [12:0]        sum25;
   logic [12:0]        x25;
   logic signed [13:0] d_in, d_ff;
   logic [7:0]         x2_ff, x3_ff;
   logic signed [25:0] prod_in, prod_ff;
   logic [20:0]        x6400;
   logic signed [26:0] num;
   logic               neg_ff, sat_ff;
   logic [12:0]        n2_ff;
   logic [25:0]        q_prod;

   assign sum25 = 13'(col_sums[0]) + 13'(col_sums[1]) + 13'(col_sums[2])
                + 13'(col_sums[3]) + 13'(col_sums[4]);
   assign x25   = 13'(center) * 13'd25;
   assign d_in  = $signed({1'b0, x25}) - $signed({1'b0, sum25});

   assign prod_in = 26'(lambda) * 26'(d_ff);

   assign x6400 = 21'(x3_ff) * SCALE;
   assign num   = $signed({6'b0, x6400}) + 27'(prod_ff);

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      x2_ff   <= center;
      prod_ff <= prod_in;
      x3_ff   <= x2_ff;
      neg_ff  <= num[26];
      sat_ff  <= num >= SAT_LIMIT;
      n2_ff   <= num[20:8];
   end

   // num / 6400 == (num >> 8) / 25, exact for num below 256 * 6400
   assign q_prod = 26'(n2_ff) * DIV_MULT;

   always_comb begin
      priority if (neg_ff) begin
         result = 8'd0;
      end else if (sat_ff) begin
         result = 8'd255;
      end else begin
         result = q_prod[DIV_SHIFT+7:DIV_SHIFT];
      end
   end

endmodule

// ----- rtl/unsharp_mask_5x5_rgb_top.sv -----
// Channel   Handshake             Payload
// req       req_valid/req_stall   req_in_red, req_in_green, req_in_blue
// rsp       rsp_valid/rsp_stall   rsp_out_red/green/blue, rsp_out_row/col, rsp_frame_last
// csr       APB psel/penable      paddr, pwdata, prdata (lambda 0x0, width 0x4, height 0x8)
//
// One pixel per clock while req_stall is low; results reach the output queue in pixel order.
// The rate is set by the single line-store port set and the five-cell window chain.
// req_stall rises when all eight output queue slots are reserved by pending results.
// Synchronous reset clears counters, pipeline valids and the queue; line stores are not cleared.
module unsharp_mask_5x5_rgb_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [9:0]  rsp_out_row,
   output logic [9:0]  rsp_out_col,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import unsh_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RCW = $clog2(MAX_HEIGHT);
   localparam int WW  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
   localparam int HW  = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
   localparam int OCW = (CW > 10) ? CW : 10;
   localparam int ORW = (RCW > 10) ? RCW : 10;
   localparam int FIFO_DEPTH = 8;
   localparam int FAW = $clog2(FIFO_DEPTH);
   localparam int FCW = $clog2(FIFO_DEPTH + 1);

   // configuration
   logic signed [11:0] lambda_ff;
   logic [10:0]        width_ff, height_ff;
   logic               cfg_wr;
   reg_idx_type        cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = reg_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= LAMBDA_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_LAMBDA: lambda_ff <= pwdata[11:0];
            REG_WIDTH:  width_ff  <= pwdata[10:0];
            REG_HEIGHT: height_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_LAMBDA: prdata = {20'd0, lambda_ff};
         REG_WIDTH:  prdata = {21'd0, width_ff};
         REG_HEIGHT: prdata = {21'd0, height_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // raster position
   logic [CW-1:0]  col_ff, col_in;
   logic [RCW-1:0] row_ff, row_in;
   logic [WW-1:0]  w_raw, w_eff, c_inc;
   logic [HW-1:0]  h_raw, h_eff, r_inc;
   logic           wrap, accept, emit_now, border_now, last_now;
   logic [OCW-1:0] cc_w;
   logic [ORW-1:0] cr_w;

   assign w_raw = WW'(width_ff);
   assign h_raw = HW'(height_ff);
   assign w_eff = (w_raw < WW'(5)) ? WW'(5) :
                  (w_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_raw;
   assign h_eff = (h_raw < HW'(5)) ? HW'(5) :
                  (h_raw > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_raw;

   assign c_inc = WW'(col_ff) + WW'(1);
   assign wrap  = c_inc >= w_eff;
   assign r_inc = wrap ? HW'(row_ff) + HW'(1) : HW'(row_ff);

   always_comb begin
      col_in = wrap ? '0 : c_inc[CW-1:0];
      row_in = (r_inc >= h_eff) ? '0 : r_inc[RCW-1:0];
   end

   assign emit_now   = (row_ff >= RCW'(2)) && (col_ff >= CW'(2));
   assign border_now = (row_ff < RCW'(4)) || (col_ff < CW'(4));
   assign last_now   = (HW'(row_ff) == h_eff - HW'(1)) && (WW'(col_ff) == w_eff - WW'(1));
   assign cr_w       = ORW'(row_ff) - ORW'(2);
   assign cc_w       = OCW'(col_ff) - OCW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // output slot reservation
   logic [FCW-1:0] credit_ff, credit_in;
   logic [FCW-1:0] count_ff;
   logic [FAW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic           push, pop;

   assign req_stall = reset || (credit_ff == FCW'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign credit_in = credit_ff + FCW'(accept && emit_now) - FCW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // line stores
   px_type    pix;
   px_type    pix_s1_ff;
   lines_type lines;

   assign pix = {req_in_blue, req_in_green, req_in_red};

   unsh_lbuf #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_lbuf (
      .clock (clock),
      .rd_en (accept),
      .slot  (row_ff[1:0]),
      .addr  (col_ff),
      .pix   (pix),
      .lines (lines)
   );

   // pipeline control
   logic           v1_ff;
   logic [4:0]     emit_ff;
   meta_type       meta_ff [5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         emit_ff <= '0;
      end else begin
         v1_ff   <= accept;
         emit_ff <= {emit_ff[3:0], accept && emit_now};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_s1_ff <= pix;
      end
      meta_ff[0] <= '{border: border_now, last: last_now, row: cr_w[9:0], col: cc_w[9:0]};
      for (int s = 1; s < 5; s++) begin
         meta_ff[s] <= meta_ff[s-1];
      end
   end

   // window: chain of five column cells, new column enters at the right
   col_type  new_col;
   csum_type new_sum;
   col_type  cell_col [5];
   csum_type cell_sum [5];

   always_comb begin
      new_col = {pix_s1_ff, lines[3], lines[2], lines[1], lines[0]};
      for (int ch = 0; ch < CH_N; ch++) begin
         new_sum[ch] = CSUM_W'(new_col[0][ch]) + CSUM_W'(new_col[1][ch])
                     + CSUM_W'(new_col[2][ch]) + CSUM_W'(new_col[3][ch])
                     + CSUM_W'(new_col[4][ch]);
      end
   end

   for (genvar j = 0; j < 5; j++) begin : g_cell
      if (j == 4) begin : g_head
         unsh_cell u_cell (
            .clock    (clock),
            .shift_en (v1_ff),
            .col_in   (new_col),
            .sum_in   (new_sum),
            .col_out  (cell_col[j]),
            .sum_out  (cell_sum[j])
         );
      end else begin : g_body
         unsh_cell u_cell (
            .clock    (clock),
            .shift_en (v1_ff),
            .col_in   (cell_col[j+1]),
            .sum_in   (cell_sum[j+1]),
            .col_out  (cell_col[j]),
            .sum_out  (cell_sum[j])
         );
      end
   end

   // per-channel sharpening arithmetic
   logic [CH_N-1:0][7:0] ch_res;

   for (genvar ch = 0; ch < CH_N; ch++) begin : g_ch
      sums5_type ch_sums;

      for (genvar j = 0; j < 5; j++) begin : g_tap
         assign ch_sums[j] = cell_sum[j][ch];
      end

      unsh_calc u_calc (
         .clock    (clock),
         .lambda   (lambda_ff),
         .col_sums (ch_sums),
         .center   (cell_col[2][2][ch]),
         .result   (ch_res[ch])
      );
   end

   // output queue
   rsp_type fifo_mem [FIFO_DEPTH];
   rsp_type wr_data, rd_data;

   assign push = emit_ff[4];
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      wr_data.red   = meta_ff[4].border ? 8'd0 : ch_res[0];
      wr_data.green = meta_ff[4].border ? 8'd0 : ch_res[1];
      wr_data.blue  = meta_ff[4].border ? 8'd0 : ch_res[2];
      wr_data.row   = meta_ff[4].row;
      wr_data.col   = meta_ff[4].col;
      wr_data.last  = meta_ff[4].last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FAW'(1);
         end
         count_ff <= count_ff + FCW'(push) - FCW'(pop);
      end
   end

   assign rd_data        = fifo_mem[rd_ptr_ff];
   assign rsp_valid      = count_ff != '0;
   assign rsp_out_red    = rd_data.red;
   assign rsp_out_green  = rd_data.green;
   assign rsp_out_blue   = rd_data.blue;
   assign rsp_out_row    = rd_data.row;
   assign rsp_out_col    = rd_data.col;
   assign rsp_frame_last = rd_data.last;

   // queued results never outnumber reserved slots
   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= credit_ff)
      else $error("output queue holds more entries than reserved");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < FCW'(FIFO_DEPTH)))
      else $error("output queue overflow");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && emit_now) |-> ##5 push)
      else $error("result not written five cycles after its pixel");

   a_pop_reserved: assert property (@(posedge clock) disable iff (reset)
      pop |-> (credit_ff != '0))
      else $error("result taken without a reservation");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import unsh_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PIXELS = 350;
   localparam int WIDE_PIXELS   = 200;
   localparam int TALL_PIXELS   = 100;

   class sharpen_scoreboard;
      px_type      line_mem [4*MAX_W];
      px_type      win [5][5];
      int unsigned row_pos;
      int unsigned col_pos;
      logic [11:0] lambda_reg;
      logic [10:0] width_reg;
      logic [10:0] height_reg;
      rsp_type     sharpened_q [$];
      int          mismatches;

      function new();
         int i;
         int j;
         for (i = 0; i < 4*MAX_W; i++) line_mem[i] = '0;
         for (i = 0; i < 5; i++)
            for (j = 0; j < 5; j++) win[i][j] = '0;
         row_pos    = 0;
         col_pos    = 0;
         lambda_reg = LAMBDA_RESET;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function int frame_width();
         if (width_reg < 5) return 5;
         if (width_reg > MAX_W) return MAX_W;
         return int'(width_reg);
      endfunction

      function int frame_height();
         if (height_reg < 5) return 5;
         if (height_reg > MAX_H) return MAX_H;
         return int'(height_reg);
      endfunction

      function void set_reg(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_LAMBDA: lambda_reg = value[11:0];
            REG_WIDTH:  width_reg  = value[10:0];
            REG_HEIGHT: height_reg = value[10:0];
            default: ;
         endcase
      endfunction

      // x + lambda*(x - mean25) in Q4.8, truncated and clipped
      function logic [7:0] sharpen_channel(int ch);
         longint total;
         longint center;
         longint num;
         int     i;
         int     j;
         total = 0;
         for (i = 0; i < 5; i++)
            for (j = 0; j < 5; j++) total += win[i][j][ch];
         center = win[2][2][ch];
         num = 6400 * center + longint'($signed(lambda_reg)) * (25 * center - total);
         if (num < 0) return 8'd0;
         if (num / 6400 > 255) return 8'd255;
         return 8'(num / 6400);
      endfunction

      function void note_pixel(px_type pix);
         px_type      column [5];
         rsp_type     res;
         int unsigned w;
         int unsigned h;
         int unsigned r;
         int unsigned c;
         int unsigned slot;
         int          i;
         int          j;
         int          ch;
         w    = frame_width();
         h    = frame_height();
         r    = row_pos;
         c    = col_pos;
         slot = r % 4;
         // slot about to be reused holds the row four above
         for (i = 0; i < 4; i++) column[i] = line_mem[((slot + i) % 4) * MAX_W + c % MAX_W];
         column[4] = pix;
         line_mem[slot * MAX_W + c % MAX_W] = pix;
         for (i = 0; i < 5; i++) begin
            for (j = 0; j < 4; j++) win[i][j] = win[i][j+1];
            win[i][4] = column[i];
         end
         if (r >= 2 && c >= 2) begin
            res.row  = 10'(r - 2);
            res.col  = 10'(c - 2);
            res.last = (r == h - 1 && c == w - 1);
            if (r - 2 < 2 || c - 2 < 2) begin
               res.red   = '0;
               res.green = '0;
               res.blue  = '0;
            end else begin
               res.red   = sharpen_channel(0);
               res.green = sharpen_channel(1);
               res.blue  = sharpen_channel(2);
            end
            sharpened_q.push_back(res);
         end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         if (r >= h) r = 0;
         col_pos = c;
         row_pos = r;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("mismatch: %s", msg);
      endtask

      task compare_field(string name, logic [9:0] got, logic [9:0] want, rsp_type ref_res);
         if (got !== want)
            report($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                             name, ref_res.row, ref_res.col, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (sharpened_q.size() == 0) begin
            report($sformatf("result row %0d col %0d with nothing pending", got.row, got.col));
            return;
         end
         want = sharpened_q.pop_front();
         compare_field("red",   got.red,   want.red,   want);
         compare_field("green", got.green, want.green, want);
         compare_field("blue",  got.blue,  want.blue,  want);
         compare_field("row",   got.row,   want.row,   want);
         compare_field("col",   got.col,   want.col,   want);
         compare_field("last",  got.last,  want.last,  want);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_red = '0;
   logic [7:0]  req_in_green = '0;
   logic [7:0]  req_in_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [9:0]  rsp_out_row;
   logic [9:0]  rsp_out_col;
   logic        rsp_frame_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bit                in_quiet = 1'b0;
   bit                out_quiet = 1'b0;
   int                stall_left = 0;
   int                idle_cycles = 0;
   sharpen_scoreboard sb;

   unsharp_mask_5x5_rgb_top #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_last(rsp_frame_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len(bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic px_type make_pixel(int kind, int idx);
      px_type p;
      int     pick;
      int     ch;
      pick = $urandom_range(0, 9);
      for (ch = 0; ch < 3; ch++) begin
         if (kind == 0 || pick < 2) p[ch] = 8'($urandom());
         else if (kind == 1) p[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else p[ch] = 8'(idx * 3 + ch * 70 + $urandom_range(0, 12));
      end
      return p;
   endfunction

   // monitors both channels, drives the result-side stall, and runs the watchdog
   always @(posedge clock) begin
      rsp_type got;
      bit      moved;
      moved = 1'b0;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = gap_len(out_quiet);
      end
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_pixel({req_in_blue, req_in_green, req_in_red});
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.red   = rsp_out_red;
            got.green = rsp_out_green;
            got.blue  = rsp_out_blue;
            got.row   = rsp_out_row;
            got.col   = rsp_out_col;
            got.last  = rsp_frame_last;
            sb.check_result(got);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_pixel(input px_type pix);
      int gap;
      gap = gap_len(in_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= pix[0];
      req_in_green <= pix[1];
      req_in_blue  <= pix[2];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_burst(input int count, input int kind);
      int k;
      for (k = 0; k < count; k++) send_pixel(make_pixel(kind, k));
      req_valid <= 1'b0;
   endtask

   // wait for every pending result, then let the pipeline empty out
   task automatic drain_results();
      do @(posedge clock); while (sb.sharpened_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic set_filter(input logic [11:0] lam, input logic [10:0] wd,
                             input logic [10:0] ht);
      csr_write(REG_LAMBDA, {20'd0, lam});
      csr_write(REG_WIDTH, {21'd0, wd});
      csr_write(REG_HEIGHT, {21'd0, ht});
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      int          r;
      int          c;
      int          w;
      int          h;
      int          count;
      int          w_cap;
      int          random_sent;
      bit          at_start;
      logic [11:0] lam;
      logic [10:0] wd;
      logic [10:0] ht;

      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 5x5 frame: one interior center, clipped high on red and low on green
      drain_results();
      set_filter(12'h7FF, 11'd5, 11'd5);
      for (r = 0; r < 5; r++)
         for (c = 0; c < 5; c++)
            if (r == 2 && c == 2) send_pixel({8'h80, 8'h00, 8'hFF});
            else send_pixel({8'(r * 40 + c * 9), 8'hFF, 8'h00});
      req_valid <= 1'b0;

      // sizes below the minimum saturate to 5, most negative lambda
      drain_results();
      set_filter(12'h800, 11'd0, 11'd3);
      send_burst(50, 0);

      // wide line (oversized width saturates), then a tall frame
      drain_results();
      set_filter(12'h100, 11'd2047, 11'd5);
      send_burst(WIDE_PIXELS, 2);
      drain_results();
      set_filter(12'd384, 11'd5, 11'd1024);
      send_burst(TALL_PIXELS, 0);

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         drain_results();
         // width may only grow at a frame start, so stored lines always cover it
         at_start = (sb.row_pos == 0 && sb.col_pos == 0);
         w_cap = (at_start || sb.frame_width() > 12) ? 12 : sb.frame_width();
         case ($urandom_range(0, 4))
            0: lam = 12'h800;
            1: lam = 12'h7FF;
            2: lam = 12'h000;
            3: lam = 12'($urandom());
            default: lam = 12'($urandom_range(64, 1024));
         endcase
         wd = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 4))
                                          : 11'($urandom_range(5, w_cap));
         case ($urandom_range(0, 9))
            0: ht = 11'($urandom_range(0, 4));
            1: ht = 11'($urandom_range(1025, 2047));
            default: ht = 11'($urandom_range(5, 10));
         endcase
         set_filter(lam, wd, ht);
         w = sb.frame_width();
         h = sb.frame_height();
         r = sb.row_pos;
         c = sb.col_pos;
         // mostly finish the frame in progress, sometimes stop mid-frame
         if (r < h && c < w && $urandom_range(0, 3) != 0) begin
            count = (h - r - 1) * w + (w - c);
            if ($urandom_range(0, 2) == 0) count += w * h;
            if (count > 300) count = $urandom_range(1, 60);
         end else begin
            count = $urandom_range(1, 60);
         end
         send_burst(count, $urandom_range(0, 2));
         random_sent += count;
      end

      drain_results();
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
